// File: rtl/lmst_pkg.sv
// Shared types, constants and codes for the block level meter with silence timer.
// Used by every module of the block but lmst_div; depends on nothing.
`default_nettype none

package lmst_pkg;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 16;
  localparam int LVL_W    = 16;
  localparam int TH_W     = 16;
  localparam int SUM_W    = 28;
  localparam int TICK_W   = 32;

  // Stream payload widths, padded to whole bytes.
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 64;

  // Saturation limits.
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // Default parameter and register reset values.
  localparam int                DEF_MAX_BLOCK = 4096;
  localparam logic [TH_W-1:0]   DEF_ACTIVITY  = 16'd327;
  localparam logic [TH_W-1:0]   DEF_QUERY     = 16'd327;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY    = 1'd1;

  // Input opcodes.
  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  // Classified item kinds handed from the front to the back.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_SAMPLE  = 2'd0;
  localparam kind_t KIND_TICK    = 2'd1;
  localparam kind_t KIND_RESTART = 2'd2;

  // Queue between front and back.
  localparam int QDEPTH = 2;

  typedef struct packed {
    kind_t              kind;
    logic [MAG_W-1:0]   mag;
    logic               last;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/lmst_front.sv
// Front end: accepts input items, drops unused opcodes, turns samples into
// magnitudes and queues classified items for the back end. Uses lmst_pkg.
`default_nettype none

module lmst_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [lmst_pkg::S_DATA_W-1:0] s_tdata,
  input  wire logic                          s_tlast,
  output logic                               q_valid,
  output lmst_pkg::item_t                    q_item,
  input  wire logic                          q_pop
);
  import lmst_pkg::*;

  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int FILL_W = $clog2(QDEPTH + 1);

  item_t               entries [QDEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [FILL_W-1:0]   fill;

  logic [OP_W-1:0]     op;
  logic [SAMPLE_W-1:0] raw;
  logic                push;
  item_t               item_in;
  logic                take;

  // Classify the incoming item; the unused opcode is accepted and dropped.
  always_comb begin
    op      = s_tdata[OP_W-1:0];
    raw     = s_tdata[OP_W +: SAMPLE_W];
    item_in.mag  = raw[SAMPLE_W-1] ? MAG_W'(-raw) : raw;
    item_in.last = s_tlast;
    push = 1'b1;
    unique case (op)
      OP_SAMPLE:  item_in.kind = KIND_SAMPLE;
      OP_TICK:    item_in.kind = KIND_TICK;
      OP_RESTART: item_in.kind = KIND_RESTART;
      default: begin
        item_in.kind = KIND_TICK;
        push = 1'b0;
      end
    endcase
  end

  assign s_tready = (fill != FILL_W'(QDEPTH));
  assign take     = s_tvalid && s_tready;
  assign q_valid  = (fill != '0);
  assign q_item   = entries[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (take && push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (take && push) begin
        wr_ptr <= PTR_W'((32'(wr_ptr) + 1) % QDEPTH);
      end
      if (q_pop) begin
        rd_ptr <= PTR_W'((32'(rd_ptr) + 1) % QDEPTH);
      end
      if ((take && push) && !q_pop) begin
        fill <= fill + 1'b1;
      end else if (!(take && push) && q_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/lmst_div.sv
// Restoring divider, one quotient bit per cycle, for the block mean.
// Depends on nothing; the operand widths come in as parameters.
`default_nettype none

module lmst_div #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 13
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [CNT_W-1:0] steps;
  logic [DVS_W:0]   trial;
  logic             fits;

  // One shift-and-subtract step.
  always_comb begin
    trial = {rem, quo[DVD_W-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (start) begin
      steps <= CNT_W'(DVD_W);
      done  <= 1'b0;
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
      done  <= (steps == CNT_W'(1));
    end
  end

  // Datapath: quotient bits shift in as dividend bits shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (steps != '0) begin
      rem <= fits ? DVS_W'(trial - {1'b0, dvs}) : DVS_W'(trial);
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: rtl/lmst_back.sv
// Back end: carries out queued items on the block accumulators and silence
// counter, runs the mean division and holds the result register. Uses lmst_pkg, lmst_div.
`default_nettype none

module lmst_back #(
  parameter int MAX_BLOCK = lmst_pkg::DEF_MAX_BLOCK
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire lmst_pkg::item_t               q_item,
  output logic                               q_pop,
  input  wire logic [lmst_pkg::TH_W-1:0]     activity_threshold,
  input  wire logic [lmst_pkg::TH_W-1:0]     query_threshold,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [lmst_pkg::M_DATA_W-1:0]      m_tdata,
  output logic                               m_tuser
);
  import lmst_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                state, state_next;
  logic [SUM_W-1:0]    sum, sum_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [MAG_W-1:0]    peak, peak_next;
  logic [TICK_W-1:0]   silence, silence_next;
  logic                ovf, ovf_next;

  logic [MAG_W-1:0]    res_peak;
  logic [TICK_W-1:0]   res_silence;
  logic                res_ovf;
  logic                res_zero;

  logic [MAG_W-1:0]    peak_upd;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_upd;
  logic [CNT_W-1:0]    count_upd;
  logic                ovf_upd;
  logic [TICK_W-1:0]   silence_blk;
  logic                block_done;
  logic                div_done;
  logic [SUM_W-1:0]    quotient;
  logic                load_out;

  assign q_pop      = q_valid && (state == ST_IDLE);
  assign block_done = q_pop && (q_item.kind == KIND_SAMPLE) && q_item.last;
  assign load_out   = (state == ST_DIV) && div_done && (!m_tvalid || m_tready);

  // Sample accumulation with length and sum saturation.
  always_comb begin
    peak_upd  = (q_item.mag > peak) ? q_item.mag : peak;
    sum_wide  = {1'b0, sum} + (SUM_W+1)'(q_item.mag);
    sum_upd   = sum;
    count_upd = count;
    ovf_upd   = ovf;
    if (count >= CNT_W'(MAX_BLOCK)) begin
      ovf_upd = 1'b1;
    end else begin
      count_upd = count + 1'b1;
      if (sum_wide > {1'b0, SUM_MAX}) begin
        sum_upd = SUM_MAX;
        ovf_upd = 1'b1;
      end else begin
        sum_upd = SUM_W'(sum_wide);
      end
    end
    silence_blk = (peak_upd > activity_threshold) ? '0 : silence;
  end

  // Next state of the accumulators and the silence counter.
  always_comb begin
    sum_next     = sum;
    count_next   = count;
    peak_next    = peak;
    ovf_next     = ovf;
    silence_next = silence;
    state_next   = state;
    if (q_pop) begin
      unique case (q_item.kind)
        KIND_TICK: begin
          if (silence != TICK_MAX) begin
            silence_next = silence + 1'b1;
          end
        end
        KIND_RESTART: begin
          sum_next     = '0;
          count_next   = '0;
          peak_next    = '0;
          ovf_next     = 1'b0;
          silence_next = '0;
        end
        KIND_SAMPLE: begin
          if (q_item.last) begin
            sum_next     = '0;
            count_next   = '0;
            peak_next    = '0;
            ovf_next     = 1'b0;
            silence_next = silence_blk;
            state_next   = ST_DIV;
          end else begin
            sum_next   = sum_upd;
            count_next = count_upd;
            peak_next  = peak_upd;
            ovf_next   = ovf_upd;
          end
        end
        default: begin
          state_next = state;
        end
      endcase
    end else if (load_out) begin
      state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      sum     <= '0;
      count   <= '0;
      peak    <= '0;
      ovf     <= 1'b0;
      silence <= '0;
    end else begin
      state   <= state_next;
      sum     <= sum_next;
      count   <= count_next;
      peak    <= peak_next;
      ovf     <= ovf_next;
      silence <= silence_next;
    end
  end

  // Fields of the finished block that wait for the mean.
  always_ff @(posedge clk) begin
    if (block_done) begin
      res_peak    <= peak_upd;
      res_silence <= (peak_upd > query_threshold) ? '0 : silence_blk;
      res_ovf     <= ovf_upd;
      res_zero    <= (count_upd == '0);
    end
  end

  lmst_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (block_done),
    .dividend (sum_upd),
    .divisor  (count_upd),
    .done     (div_done),
    .quotient (quotient)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {res_silence, res_peak, res_zero ? LVL_W'(0) : quotient[LVL_W-1:0]};
      m_tuser <= res_ovf;
    end
  end

  // The back end takes nothing from the queue while a division is pending.
  a_no_pop_in_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !q_pop)
    else $error("item taken during division");

  // A result is loaded only from a completed division.
  a_load_after_div: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (div_done && (state == ST_DIV)))
    else $error("result loaded without finished division");

  // A restart leaves the block and the silence counter cleared.
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (q_pop && (q_item.kind == KIND_RESTART)) |=>
      (silence == '0 && count == '0 && sum == '0 && !ovf))
    else $error("restart did not clear state");

  // The sample count never passes the block limit.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BLOCK))
    else $error("sample count beyond block limit");

endmodule

`default_nettype wire

// File: rtl/block_level_meter_silence_timer_core.sv
// Block level meter with silence timer, top level.
//
// Input stream s_*: one item per handshake. tdata bits [1:0] opcode (sample,
// tick, restart; the fourth code is dropped), bits [17:2] the signed sample;
// tlast marks the last sample of a block. Output stream m_*: one item per
// finished block with mean and peak magnitude, silence ticks, and the
// overlong flag in tuser. The user is to write thresholds through cfg_we/
// cfg_index/cfg_data only while the block is idle; the block does not enforce it.
// Throughput: ticks, restarts and non-final samples are taken one per cycle
// through a two-entry queue while the back end is not busy with a division. The
// last sample of a block leaves the queue and starts a restoring divider that
// yields one quotient bit per cycle; when all 28 quotient bits are done, the
// result is loaded into the output register as soon as that register is free.
// The divider bounds the block rate.
// Input is still accepted into the queue while a result waits in the output
// register; when the receiver stalls and the queue fills, s_tready drops.
// Reset (rst, synchronous) clears accumulators, the silence counter, the
// queue and the output register, and returns both thresholds to 327.
// Depends on lmst_pkg, lmst_front, lmst_back and lmst_div.
`default_nettype none

module block_level_meter_silence_timer_core #(
  parameter int MAX_BLOCK = lmst_pkg::DEF_MAX_BLOCK
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [1:0] opcode, [17:2] sample, [23:18] zero
  input  wire logic [lmst_pkg::S_DATA_W-1:0]   s_tdata,
  input  wire logic                            s_tlast,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [15:0] mean_level, [31:16] peak_level, [63:32] silence_ticks
  output logic [lmst_pkg::M_DATA_W-1:0]        m_tdata,
  // [0] overlong
  output logic                                 m_tuser,
  input  wire logic                            cfg_we,
  input  wire logic [lmst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lmst_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lmst_pkg::*;

  logic [TH_W-1:0] activity_threshold;
  logic [TH_W-1:0] query_threshold;
  logic            q_valid;
  logic            q_pop;
  item_t           q_item;

  // Threshold registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      activity_threshold <= DEF_ACTIVITY;
      query_threshold    <= DEF_QUERY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVITY: activity_threshold <= TH_W'(cfg_data);
        REG_QUERY:    query_threshold    <= TH_W'(cfg_data);
        default:      activity_threshold <= activity_threshold;
      endcase
    end
  end

  lmst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  lmst_back #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .activity_threshold (activity_threshold),
    .query_threshold    (query_threshold),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata),
    .m_tuser            (m_tuser)
  );

endmodule

`default_nettype wire

// File: test/block_level_meter_silence_timer_checker.sv
// Checker for the block level meter: watches the input, output and register write channels,
// keeps its own copy of the meter state and compares every output item with its prediction.
// Depends on lmst_pkg for widths, opcodes and register indexes.
module block_level_meter_silence_timer_checker
  import lmst_pkg::*;
#(
  parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_DATA_W-1:0]   m_tdata,
  input  logic                  m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    reports_due
);

  // One block report as the meter should emit it.
  typedef struct packed {
    logic [LVL_W-1:0]  mean;
    logic [LVL_W-1:0]  peak;
    logic [TICK_W-1:0] silence;
    logic              overlong;
  } level_report_t;

  level_report_t     report_q [$];

  // Mirror of the meter state and its two thresholds.
  logic [TH_W-1:0]   act_level;
  logic [TH_W-1:0]   query_level;
  logic [SUM_W-1:0]  mag_sum;
  int                sample_cnt;
  logic [MAG_W-1:0]  peak_mag;
  logic [TICK_W-1:0] quiet_ticks;
  logic              overflow_seen;

  task automatic clear_block();
    mag_sum       = '0;
    sample_cnt    = 0;
    peak_mag      = '0;
    overflow_seen = 1'b0;
  endtask

  // Update the mirror for one accepted item; a closing sample queues its report.
  task automatic meter_item(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp,
                            input logic last);
    logic [MAG_W:0] mag;
    level_report_t  rep;
    case (op)
      OP_TICK: begin
        if (quiet_ticks != TICK_MAX) quiet_ticks = quiet_ticks + 1'b1;
      end
      OP_RESTART: begin
        clear_block();
        quiet_ticks = '0;
      end
      OP_SAMPLE: begin
        mag = smp[SAMPLE_W-1] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
        if (mag > peak_mag) peak_mag = mag[MAG_W-1:0];
        // Past the block limit only the peak keeps moving.
        if (sample_cnt >= MAX_BLOCK) begin
          overflow_seen = 1'b1;
        end else begin
          sample_cnt++;
          if (mag_sum > SUM_MAX - mag) begin
            mag_sum       = SUM_MAX;
            overflow_seen = 1'b1;
          end else begin
            mag_sum = mag_sum + mag;
          end
        end
        if (last) begin
          rep.mean = (sample_cnt != 0) ? LVL_W'(mag_sum / sample_cnt) : '0;
          rep.peak = peak_mag;
          if (peak_mag > act_level) quiet_ticks = '0;
          rep.silence  = (peak_mag > query_level) ? '0 : quiet_ticks;
          rep.overlong = overflow_seen;
          report_q = {report_q, rep};
          clear_block();
        end
      end
      default: begin
        // The unused opcode is dropped by the meter.
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [TICK_W-1:0] want,
                             input logic [TICK_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    level_report_t want;
    if (rst) begin
      act_level   = DEF_ACTIVITY;
      query_level = DEF_QUERY;
      quiet_ticks = '0;
      clear_block();
      report_q.delete();
      fail_count  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ACTIVITY: act_level = cfg_data;
          REG_QUERY:    query_level = cfg_data;
          default: ;
        endcase
      end
      // Compare each output item with the oldest report waiting.
      if (m_tvalid && m_tready) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected output item, expected none, got %h/%b", $time,
                   m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = report_q.pop_front();
          check_field("mean_level", TICK_W'(want.mean), TICK_W'(m_tdata[15:0]));
          check_field("peak_level", TICK_W'(want.peak), TICK_W'(m_tdata[31:16]));
          check_field("silence_ticks", want.silence, m_tdata[63:32]);
          check_field("overlong", TICK_W'(want.overlong), TICK_W'(m_tuser));
        end
      end
      if (s_tvalid && s_tready)
        meter_item(s_tdata[OP_W-1:0], s_tdata[OP_W+SAMPLE_W-1:OP_W], s_tlast);
    end
    reports_due = report_q.size();
  end

endmodule

// File: test/block_level_meter_silence_timer_core_tb.sv
// Testbench top for the block level meter: drives directed and random sample, tick and
// restart items under several threshold settings and idling patterns, and gives the verdict.
// Depends on lmst_pkg, the meter RTL and block_level_meter_silence_timer_checker.
module block_level_meter_silence_timer_core_tb;
  import lmst_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int DRAIN_CYCLES    = 64;
  localparam int CYCLE_LIMIT     = 1000000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int reports_due;
  int cycle_cnt = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int items_sent = 0;
  int act_lvl = DEF_ACTIVITY;
  int qry_lvl = DEF_QUERY;

  always #10 clk = ~clk;

  block_level_meter_silence_timer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  block_level_meter_silence_timer_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .reports_due (reports_due)
  );

  // Receiver readiness, redrawn every cycle.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Hard stop in case the meter hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one item, with random idle cycles in front, and hold it until accepted.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp,
                           input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W-OP_W-SAMPLE_W){1'b0}}, smp, op};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Samples lean toward full scale, the threshold edges and small values, the rest spread wide.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = 32768;
      1: return 16'h7fff;
      2: begin
        v = ($urandom_range(0, 1) ? act_lvl : qry_lvl) + $urandom_range(0, 4) - 2;
        if (v < 0) v = 0;
        if (v > 32768) v = 32768;
      end
      3, 4, 5: v = $urandom_range(0, 600);
      default: return SAMPLE_W'($urandom);
    endcase
    return $urandom_range(0, 1) ? SAMPLE_W'(-v) : SAMPLE_W'(v);
  endfunction

  // A well-formed block, now and then with ticks slipped between its samples.
  task automatic send_block(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8)
        send_item(OP_TICK, SAMPLE_W'($urandom), $urandom_range(0, 1));
      send_item(OP_SAMPLE, pick_sample(), i == len - 1);
    end
  endtask

  task automatic send_random_items(input int count);
    int goal;
    int r;
    goal = items_sent + count;
    while (items_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 65)
        send_block($urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 8));
      else if (r < 85)
        repeat ($urandom_range(1, 6))
          send_item(OP_TICK, SAMPLE_W'($urandom), $urandom_range(0, 1));
      else if (r < 90)
        send_item(OP_RESTART, SAMPLE_W'($urandom), $urandom_range(0, 1));
      else if (r < 95)
        send_item(OP_UNUSED, SAMPLE_W'($urandom), $urandom_range(0, 1));
      else
        // A stray open sample that becomes part of the next block.
        send_item(OP_SAMPLE, pick_sample(), 1'b0);
    end
  endtask

  task automatic write_thresholds(input int act, input int qry);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ACTIVITY;
    cfg_data  <= act[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_QUERY;
    cfg_data  <= qry[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we  <= 1'b0;
    act_lvl = act & 16'hffff;
    qry_lvl = qry & 16'hffff;
  endtask

  // Wait for all reports, then let the divider and the input queue settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
        default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
      endcase
      case (p)
        0: ;
        1: write_thresholds(0, 0);
        2: write_thresholds(32768, 32768);
        3: write_thresholds(16'hffff, 1000);
        4: write_thresholds(100, 16'hffff);
        5: write_thresholds($urandom_range(0, 1200), $urandom_range(0, 1200));
        default: write_thresholds(DEF_ACTIVITY, DEF_QUERY);
      endcase
      if (p == 0) begin
        // Single-sample blocks at zero and both full-scale ends.
        send_item(OP_SAMPLE, 16'h0000, 1'b1);
        send_item(OP_SAMPLE, 16'h7fff, 1'b1);
        send_item(OP_SAMPLE, 16'h8000, 1'b1);
        // Mixed signs with a mean that must be floored.
        send_item(OP_SAMPLE, 16'hffff, 1'b0);
        send_item(OP_SAMPLE, 16'h0001, 1'b0);
        send_item(OP_SAMPLE, 16'hfffe, 1'b1);
        // Quiet block after ticks reports the count.
        repeat (3) send_item(OP_TICK, 16'h0000, 1'b0);
        send_item(OP_SAMPLE, 16'd100, 1'b1);
        // A tick carrying a block end is just a tick; a peak at the threshold is quiet.
        send_item(OP_TICK, 16'h0000, 1'b1);
        send_item(OP_SAMPLE, 16'd327, 1'b1);
        // One above the threshold is loud.
        send_item(OP_SAMPLE, 16'd328, 1'b1);
        // Unused opcode and restart, both with a block end set.
        send_item(OP_UNUSED, 16'hffff, 1'b1);
        send_item(OP_RESTART, 16'h0000, 1'b1);
        send_item(OP_TICK, 16'h0000, 1'b0);
        send_item(OP_SAMPLE, 16'd5, 1'b1);
        // A restart in the middle of a block drops the partial sums.
        send_item(OP_SAMPLE, 16'd1000, 1'b0);
        send_item(OP_RESTART, 16'h0000, 1'b0);
        send_item(OP_SAMPLE, 16'd2, 1'b1);
        send_item(OP_TICK, 16'h0000, 1'b0);
        send_item(OP_SAMPLE, -16'sd328, 1'b1);
      end
      send_random_items(ITEMS_PER_PHASE);
      wait_idle();
    end
    if (fail_count == 0 && reports_due == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
